// File: sv/ptst_pkg.sv
// ----------------------------------------------------------------------------
// ptst_pkg
// Shared types and constants of the priority timer slot table.
// ----------------------------------------------------------------------------
package ptst_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef enum logic [2:0] {
        ACT_REGISTER   = 3'd0,
        ACT_UNREGISTER = 3'd1,
        ACT_SET_VALUE  = 3'd2,
        ACT_GET_VALUE  = 3'd3,
        ACT_POSITION   = 3'd4,
        ACT_TRIGGER    = 3'd5
    } t_action;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] id;
        logic [7:0]        prio;
    } t_entry;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic [SLOT_W-1:0] id;
        logic [7:0]        prio;
    } t_queue_cmd;

    typedef struct packed {
        logic              alloc;
        logic              free_slot;
        logic              set_alarm;
        logic [SLOT_W-1:0] id;
        logic [63:0]       ticks;
        logic [15:0]       handle;
    } t_slot_cmd;

endpackage

// File: sv/ptst_cell.sv
// ----------------------------------------------------------------------------
// ptst_cell
// One position of the ordered queue: holds an entry, takes a new entry or
// its left neighbor's on insert, and its right neighbor's on removal.
// ----------------------------------------------------------------------------
module ptst_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptst_pkg::t_queue_cmd i_cmd,
    input  ptst_pkg::t_entry     i_prev_q,
    input  logic                 i_prev_take,
    input  logic                 i_prev_del,
    input  ptst_pkg::t_entry     i_next_q,
    output ptst_pkg::t_entry     o_q,
    output logic                 o_take,
    output logic                 o_del
);

    ptst_pkg::t_entry r_q;
    ptst_pkg::t_entry n_q;
    ptst_pkg::t_entry new_entry;

    assign o_take = !r_q.valid || (i_cmd.prio < r_q.prio);
    assign o_del  = i_prev_del || (r_q.valid && (r_q.id == i_cmd.id));

    always_comb begin
        new_entry.valid = 1'b1;
        new_entry.id    = i_cmd.id;
        new_entry.prio  = i_cmd.prio;
        n_q = r_q;
        if (i_cmd.ins && o_take) begin
            n_q = i_prev_take ? i_prev_q : new_entry;
        end else if (i_cmd.del && o_del) begin
            n_q = i_next_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// File: sv/ptst_slot_table.sv
// ----------------------------------------------------------------------------
// ptst_slot_table
// Per-slot used bit, alarm tick value and callback handle.
// ----------------------------------------------------------------------------
module ptst_slot_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ptst_pkg::t_slot_cmd               i_cmd,
    input  logic [ptst_pkg::SLOT_W-1:0]       i_rd_id,
    output logic [ptst_pkg::NUM_TIMERS-1:0]   o_used,
    output logic [63:0]                       o_rd_alarm,
    output logic [15:0]                       o_rd_handler
);

    logic [ptst_pkg::NUM_TIMERS-1:0] r_used;
    logic [63:0]                     r_alarm   [ptst_pkg::NUM_TIMERS];
    logic [15:0]                     r_handler [ptst_pkg::NUM_TIMERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.alloc) begin
            r_used[i_cmd.id] <= 1'b1;
        end else if (i_cmd.free_slot) begin
            r_used[i_cmd.id] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_alarm[i_cmd.id]   <= '0;
            r_handler[i_cmd.id] <= i_cmd.handle;
        end else if (i_cmd.free_slot) begin
            r_alarm[i_cmd.id]   <= '0;
            r_handler[i_cmd.id] <= '0;
        end else if (i_cmd.set_alarm) begin
            r_alarm[i_cmd.id]   <= i_cmd.ticks;
        end
    end

    assign o_used       = r_used;
    assign o_rd_alarm   = r_alarm[i_rd_id];
    assign o_rd_handler = r_handler[i_rd_id];

endmodule

// File: sv/priority_timer_slot_table_top.sv
// ----------------------------------------------------------------------------
// priority_timer_slot_table_top
// Timer slot table with a priority-ordered queue built from a row of cells.
//
// Usage:
//   Drive the input fields and raise start while busy is low; that edge is
//   the transfer of one command. busy is then high for one cycle while the
//   command executes against the slot table and the queue.
//   The result appears on the o_ outputs for exactly one cycle, marked by
//   o_done, registered at the end of the execute cycle, and is taken at
//   the next edge. busy is low again in the o_done cycle, so a new command
//   may be taken there.
//   A new command is not taken while one executes; all queue cells shift
//   at once in the execute state.
//   Register inserts behind all entries of equal or lower priority number;
//   unregister closes the gap in the queue in the same cycle.
//   Reset (synchronous, active low) frees every slot and empties the queue;
//   no command is pending afterwards.
//   The receiver cannot stall: o_done and its payload are valid for one
//   cycle only and must be taken then.
// ----------------------------------------------------------------------------
module priority_timer_slot_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_prio_level,
    input  logic [7:0]  i_slot_index,
    input  logic [7:0]  i_queue_position,
    input  logic [63:0] i_alarm_ticks,
    input  logic [15:0] i_handler_handle,
    output logic        o_done,
    output logic        o_failed,
    output logic [7:0]  o_slot_out,
    output logic [63:0] o_ticks_out,
    output logic        o_fire,
    output logic [15:0] o_fire_handle
);

    localparam int N  = ptst_pkg::NUM_TIMERS;
    localparam int SW = ptst_pkg::SLOT_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state            r_state;
    t_state            n_state;
    ptst_pkg::t_action r_action;
    logic [7:0]        r_prio;
    logic [7:0]        r_slot;
    logic [7:0]        r_pos;
    logic [63:0]       r_ticks;
    logic [15:0]       r_handle;

    logic        r_done;
    logic        r_failed;
    logic [7:0]  r_slot_out;
    logic [63:0] r_ticks_out;
    logic        r_fire;
    logic [15:0] r_fire_handle;

    logic        n_failed;
    logic [7:0]  n_slot_out;
    logic [63:0] n_ticks_out;
    logic        n_fire;
    logic [15:0] n_fire_handle;

    ptst_pkg::t_queue_cmd q_cmd;
    ptst_pkg::t_slot_cmd  s_cmd;
    ptst_pkg::t_entry     cell_q [N];
    logic [N-1:0]         cell_take;
    logic [N-1:0]         cell_del;
    logic [N-1:0]         q_valid;

    logic [N-1:0]  used;
    logic [63:0]   rd_alarm;
    logic [15:0]   rd_handler;
    logic [SW-1:0] slot_id;
    logic [SW-1:0] free_id;
    logic          have_free;
    logic          id_ok;
    logic          pos_ok;
    logic          queue_full;
    logic          accept;
    logic          exec;
    ptst_pkg::t_entry pos_entry;

    assign accept  = start && !busy;
    assign exec    = (r_state == ST_EXEC);
    assign busy    = exec;
    assign slot_id = r_slot[SW-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= ptst_pkg::t_action'(i_action);
            r_prio   <= i_prio_level;
            r_slot   <= i_slot_index;
            r_pos    <= i_queue_position;
            r_ticks  <= i_alarm_ticks;
            r_handle <= i_handler_handle;
        end
        if (exec) begin
            r_failed      <= n_failed;
            r_slot_out    <= n_slot_out;
            r_ticks_out   <= n_ticks_out;
            r_fire        <= n_fire;
            r_fire_handle <= n_fire_handle;
        end
    end

    ptst_slot_table u_slots (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .i_rd_id      (slot_id),
        .o_used       (used),
        .o_rd_alarm   (rd_alarm),
        .o_rd_handler (rd_handler)
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        ptst_pkg::t_entry prev_q;
        ptst_pkg::t_entry next_q;
        logic             prev_take;
        logic             prev_del;
        if (g == 0) begin : g_head
            assign prev_q    = '0;
            assign prev_take = 1'b0;
            assign prev_del  = 1'b0;
        end else begin : g_body
            assign prev_q    = cell_q[g-1];
            assign prev_take = cell_take[g-1];
            assign prev_del  = cell_del[g-1];
        end
        if (g == N - 1) begin : g_tail
            assign next_q = '0;
        end else begin : g_link
            assign next_q = cell_q[g+1];
        end
        ptst_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (q_cmd),
            .i_prev_q    (prev_q),
            .i_prev_take (prev_take),
            .i_prev_del  (prev_del),
            .i_next_q    (next_q),
            .o_q         (cell_q[g]),
            .o_take      (cell_take[g]),
            .o_del       (cell_del[g])
        );
        assign q_valid[g] = cell_q[g].valid;
    end

    always_comb begin
        free_id   = '0;
        have_free = 1'b0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!used[i]) begin
                free_id   = SW'(i);
                have_free = 1'b1;
            end
        end
    end

    assign queue_full = q_valid[N-1];
    assign id_ok      = (r_slot < 8'(N)) && used[slot_id];
    assign pos_entry  = cell_q[r_pos[SW-1:0]];
    assign pos_ok     = (r_pos < 8'(N)) && pos_entry.valid && used[pos_entry.id];

    always_comb begin
        n_failed      = 1'b1;
        n_slot_out    = '0;
        n_ticks_out   = '0;
        n_fire        = 1'b0;
        n_fire_handle = '0;
        q_cmd         = '0;
        s_cmd         = '0;
        q_cmd.id      = slot_id;
        q_cmd.prio    = r_prio;
        s_cmd.id      = slot_id;
        s_cmd.ticks   = r_ticks;
        s_cmd.handle  = r_handle;
        if (exec) begin
            unique case (r_action)
                ptst_pkg::ACT_REGISTER: begin
                    if (!queue_full && have_free) begin
                        q_cmd.ins   = 1'b1;
                        q_cmd.id    = free_id;
                        s_cmd.alloc = 1'b1;
                        s_cmd.id    = free_id;
                        n_failed    = 1'b0;
                        n_slot_out  = 8'(free_id);
                    end
                end
                ptst_pkg::ACT_UNREGISTER: begin
                    if (id_ok) begin
                        q_cmd.del       = 1'b1;
                        s_cmd.free_slot = 1'b1;
                        n_failed        = 1'b0;
                    end
                end
                ptst_pkg::ACT_SET_VALUE: begin
                    if (id_ok) begin
                        s_cmd.set_alarm = 1'b1;
                        n_failed        = 1'b0;
                    end
                end
                ptst_pkg::ACT_GET_VALUE: begin
                    if (id_ok) begin
                        n_ticks_out = rd_alarm;
                        n_failed    = 1'b0;
                    end
                end
                ptst_pkg::ACT_POSITION: begin
                    if (pos_ok) begin
                        n_slot_out = 8'(pos_entry.id);
                        n_failed   = 1'b0;
                    end
                end
                ptst_pkg::ACT_TRIGGER: begin
                    if (id_ok) begin
                        n_failed = 1'b0;
                        if (rd_handler != '0) begin
                            n_fire        = 1'b1;
                            n_fire_handle = rd_handler;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_failed      = r_failed;
    assign o_slot_out    = r_slot_out;
    assign o_ticks_out   = r_ticks_out;
    assign o_fire        = r_fire;
    assign o_fire_handle = r_fire_handle;

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_EXEC))
        else $error("result strobe without an executed command");

    a_fail_clears_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_failed) |-> (o_slot_out == '0 && o_ticks_out == '0 && !o_fire))
        else $error("failed result carries payload");

    a_fire_has_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_fire) |-> (o_fire_handle != '0))
        else $error("fire with zero handle");

    a_queue_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((q_valid + N'(1)) & q_valid) == '0)
        else $error("queue entries not contiguous");

    a_queue_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(q_valid) == $countones(used))
        else $error("queue length differs from used slot count");

endmodule

// File: verif/tb_priority_timer_slot_table_top.sv
// ----------------------------------------------------------------------------
// tb_priority_timer_slot_table_top
// Self-checking bench for the timer slot table and its priority queue.
// A directed table covers empty-table failures, bad ids and positions,
// extreme field values, a full queue and reserved actions. Random commands
// follow in three phases with different sender idle rates. Every result is
// compared field by field with a listed value or a behavioral slot table copy.
// ----------------------------------------------------------------------------
module tb_priority_timer_slot_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TIMERS = ptst_pkg::NUM_TIMERS;
    localparam int SLOT_W     = ptst_pkg::SLOT_W;
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;
    localparam int STALL_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 242;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  prio;
        logic [7:0]  idx;
        logic [7:0]  pos;
        logic [63:0] ticks;
        logic [15:0] handle;
    } t_cmd;

    typedef struct packed {
        logic        failed;
        logic [7:0]  slot;
        logic [63:0] ticks;
        logic        fire;
        logic [15:0] handle;
    } t_res;

    typedef struct {
        t_cmd c;
        bit   typed;
        t_res r;
    } t_step;

    localparam t_res RES_FAIL = '{1'b1, 8'd0, 64'd0, 1'b0, 16'd0};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_action;
    logic [7:0]  i_prio_level;
    logic [7:0]  i_slot_index;
    logic [7:0]  i_queue_position;
    logic [63:0] i_alarm_ticks;
    logic [15:0] i_handler_handle;
    logic        o_done;
    logic        o_failed;
    logic [7:0]  o_slot_out;
    logic [63:0] o_ticks_out;
    logic        o_fire;
    logic [15:0] o_fire_handle;

    bit              slot_used    [NUM_TIMERS];
    logic [7:0]      slot_prio    [NUM_TIMERS];
    logic [63:0]     slot_alarm   [NUM_TIMERS];
    logic [15:0]     slot_handler [NUM_TIMERS];
    logic [SLOT_W-1:0] ord_entry  [NUM_TIMERS];
    bit              ord_valid    [NUM_TIMERS];

    t_res  pending_results[$];
    t_step directed_steps[$];
    t_res  mon_exp;
    int    mismatch_count = 0;
    int    stall_cycles = 0;

    priority_timer_slot_table_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_prio_level     (i_prio_level),
        .i_slot_index     (i_slot_index),
        .i_queue_position (i_queue_position),
        .i_alarm_ticks    (i_alarm_ticks),
        .i_handler_handle (i_handler_handle),
        .o_done           (o_done),
        .o_failed         (o_failed),
        .o_slot_out       (o_slot_out),
        .o_ticks_out      (o_ticks_out),
        .o_fire           (o_fire),
        .o_fire_handle    (o_fire_handle)
    );

    always #6 i_clk = ~i_clk;

    function automatic void clear_table();
        for (int i = 0; i < NUM_TIMERS; i++) begin
            slot_used[i]    = 1'b0;
            slot_prio[i]    = '0;
            slot_alarm[i]   = '0;
            slot_handler[i] = '0;
            ord_entry[i]    = '0;
            ord_valid[i]    = 1'b0;
        end
    endfunction

    function automatic bit slot_live(logic [7:0] ix);
        return (ix < NUM_TIMERS) && slot_used[ix];
    endfunction

    function automatic t_res timer_table_step(t_cmd c);
        t_res r;
        int   id;
        int   pos;
        bit   found;
        r = RES_FAIL;
        case (c.action)
            ptst_pkg::ACT_REGISTER: begin
                if (!ord_valid[NUM_TIMERS-1]) begin
                    id = NUM_TIMERS;
                    for (int i = NUM_TIMERS - 1; i >= 0; i--)
                        if (!slot_used[i]) id = i;
                    pos = NUM_TIMERS;
                    for (int i = NUM_TIMERS - 1; i >= 0; i--)
                        if (!ord_valid[i] || c.prio < slot_prio[ord_entry[i]]) pos = i;
                    if (id < NUM_TIMERS && pos < NUM_TIMERS) begin
                        for (int k = NUM_TIMERS - 1; k > pos; k--) begin
                            ord_entry[k] = ord_entry[k-1];
                            ord_valid[k] = ord_valid[k-1];
                        end
                        ord_entry[pos]   = SLOT_W'(id);
                        ord_valid[pos]   = 1'b1;
                        slot_used[id]    = 1'b1;
                        slot_prio[id]    = c.prio;
                        slot_alarm[id]   = '0;
                        slot_handler[id] = c.handle;
                        r.failed = 1'b0;
                        r.slot   = 8'(id);
                    end
                end
            end
            ptst_pkg::ACT_UNREGISTER: begin
                if (slot_live(c.idx)) begin
                    slot_used[c.idx]    = 1'b0;
                    slot_alarm[c.idx]   = '0;
                    slot_handler[c.idx] = '0;
                    found = 1'b0;
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (!found && ord_valid[i] && ord_entry[i] == c.idx[SLOT_W-1:0]) begin
                            for (int k = i; k + 1 < NUM_TIMERS; k++) begin
                                ord_entry[k] = ord_entry[k+1];
                                ord_valid[k] = ord_valid[k+1];
                            end
                            ord_entry[NUM_TIMERS-1] = '0;
                            ord_valid[NUM_TIMERS-1] = 1'b0;
                            found = 1'b1;
                        end
                    end
                    r.failed = 1'b0;
                end
            end
            ptst_pkg::ACT_SET_VALUE: begin
                if (slot_live(c.idx)) begin
                    slot_alarm[c.idx] = c.ticks;
                    r.failed = 1'b0;
                end
            end
            ptst_pkg::ACT_GET_VALUE: begin
                if (slot_live(c.idx)) begin
                    r.ticks  = slot_alarm[c.idx];
                    r.failed = 1'b0;
                end
            end
            ptst_pkg::ACT_POSITION: begin
                if (c.pos < NUM_TIMERS && ord_valid[c.pos]
                        && slot_used[ord_entry[c.pos]]) begin
                    r.slot   = 8'(ord_entry[c.pos]);
                    r.failed = 1'b0;
                end
            end
            ptst_pkg::ACT_TRIGGER: begin
                if (slot_live(c.idx)) begin
                    r.failed = 1'b0;
                    if (slot_handler[c.idx] != '0) begin
                        r.fire   = 1'b1;
                        r.handle = slot_handler[c.idx];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void add_step(logic [2:0] act, logic [7:0] pr, logic [7:0] ix,
                                     logic [7:0] ps, logic [63:0] tk, logic [15:0] hd,
                                     bit typed = 1'b0, t_res r = RES_FAIL);
        t_step s;
        s.c     = '{act, pr, ix, ps, tk, hd};
        s.typed = typed;
        s.r     = r;
        directed_steps.push_back(s);
    endfunction

    function automatic t_cmd make_random_cmd();
        t_cmd c;
        int   sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)      c.action = ptst_pkg::ACT_REGISTER;
        else if (sel < 43) c.action = ptst_pkg::ACT_UNREGISTER;
        else if (sel < 58) c.action = ptst_pkg::ACT_SET_VALUE;
        else if (sel < 73) c.action = ptst_pkg::ACT_GET_VALUE;
        else if (sel < 86) c.action = ptst_pkg::ACT_POSITION;
        else if (sel < 97) c.action = ptst_pkg::ACT_TRIGGER;
        else               c.action = ($urandom_range(0, 1) != 0) ? ACT_RSVD7 : ACT_RSVD6;
        c.prio   = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3))
                                               : 8'($urandom_range(0, 255));
        c.idx    = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, NUM_TIMERS - 1))
                                                : 8'($urandom_range(0, 255));
        c.pos    = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, NUM_TIMERS - 1))
                                                : 8'($urandom_range(0, 255));
        c.ticks  = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom, $urandom};
        c.handle = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        return c;
    endfunction

    task automatic issue_cmd(t_cmd c, bit typed, t_res r, int idle_pct);
        t_res p;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start            <= 1'b1;
        i_action         <= c.action;
        i_prio_level     <= c.prio;
        i_slot_index     <= c.idx;
        i_queue_position <= c.pos;
        i_alarm_ticks    <= c.ticks;
        i_handler_handle <= c.handle;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        p = timer_table_step(c);
        pending_results.push_back(typed ? r : p);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no transfer outstanding: failed %0h slot %0h",
                         $time, o_failed, o_slot_out);
                mismatch_count++;
            end else begin
                mon_exp = pending_results.pop_front();
                check_field("failed", mon_exp.failed, o_failed);
                check_field("slot_out", mon_exp.slot, o_slot_out);
                check_field("ticks_out", mon_exp.ticks, o_ticks_out);
                check_field("fire", mon_exp.fire, o_fire);
                check_field("fire_handle", mon_exp.handle, o_fire_handle);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("priority_timer_slot_table_top regression: fail");
            $finish;
        end
    end

    initial begin
        int idle_pct;
        clear_table();
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_action         <= '0;
        i_prio_level     <= '0;
        i_slot_index     <= '0;
        i_queue_position <= '0;
        i_alarm_ticks    <= '0;
        i_handler_handle <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_step(ptst_pkg::ACT_GET_VALUE,  8'h00, 8'h00, 8'h00, 64'd0, 16'h0000, 1'b1,
                 RES_FAIL);
        add_step(ptst_pkg::ACT_POSITION,   8'h00, 8'h00, 8'h00, 64'd0, 16'h0000, 1'b1,
                 RES_FAIL);
        add_step(ptst_pkg::ACT_TRIGGER,    8'h00, 8'h00, 8'h00, 64'd0, 16'h0000, 1'b1,
                 RES_FAIL);
        add_step(ptst_pkg::ACT_UNREGISTER, 8'h00, 8'h00, 8'h00, 64'd0, 16'h0000, 1'b1,
                 RES_FAIL);
        add_step(ACT_RSVD6,                8'hFF, 8'h00, 8'h00, '1,    16'hFFFF, 1'b1,
                 RES_FAIL);
        add_step(ACT_RSVD7,                8'h00, 8'h00, 8'h00, '1,    16'hFFFF, 1'b1,
                 RES_FAIL);
        add_step(ptst_pkg::ACT_REGISTER,   8'hFF, 8'h00, 8'h00, 64'd0, 16'hFFFF, 1'b1,
                 '{1'b0, 8'd0, 64'd0, 1'b0, 16'd0});
        add_step(ptst_pkg::ACT_REGISTER,   8'h00, 8'h00, 8'h00, 64'd0, 16'h0000, 1'b1,
                 '{1'b0, 8'd1, 64'd0, 1'b0, 16'd0});
        add_step(ptst_pkg::ACT_POSITION,   8'h00, 8'h00, 8'h00, 64'd0, 16'h0000, 1'b1,
                 '{1'b0, 8'd1, 64'd0, 1'b0, 16'd0});
        add_step(ptst_pkg::ACT_POSITION,   8'h00, 8'h00, 8'h01, 64'd0, 16'h0000, 1'b1,
                 '{1'b0, 8'd0, 64'd0, 1'b0, 16'd0});
        add_step(ptst_pkg::ACT_POSITION,   8'h00, 8'h00, 8'h02, 64'd0, 16'h0000, 1'b1,
                 RES_FAIL);
        add_step(ptst_pkg::ACT_SET_VALUE,  8'h00, 8'h00, 8'h00, '1,    16'h0000, 1'b1,
                 '{1'b0, 8'd0, 64'd0, 1'b0, 16'd0});
        add_step(ptst_pkg::ACT_GET_VALUE,  8'h00, 8'h00, 8'h00, 64'd0, 16'h0000, 1'b1,
                 '{1'b0, 8'd0, '1, 1'b0, 16'd0});
        add_step(ptst_pkg::ACT_TRIGGER,    8'h00, 8'h00, 8'h00, 64'd0, 16'h0000, 1'b1,
                 '{1'b0, 8'd0, 64'd0, 1'b1, 16'hFFFF});
        add_step(ptst_pkg::ACT_TRIGGER,    8'h00, 8'h01, 8'h00, 64'd0, 16'h0000, 1'b1,
                 '{1'b0, 8'd0, 64'd0, 1'b0, 16'd0});
        add_step(ptst_pkg::ACT_SET_VALUE,  8'h00, 8'hFF, 8'h00, '1,    16'h0000, 1'b1,
                 RES_FAIL);
        add_step(ptst_pkg::ACT_GET_VALUE,  8'h00, 8'h08, 8'h00, 64'd0, 16'h0000, 1'b1,
                 RES_FAIL);
        add_step(ptst_pkg::ACT_POSITION,   8'h00, 8'h00, 8'hFF, 64'd0, 16'h0000, 1'b1,
                 RES_FAIL);
        add_step(ptst_pkg::ACT_POSITION,   8'h00, 8'h00, 8'h08, 64'd0, 16'h0000, 1'b1,
                 RES_FAIL);
        add_step(ptst_pkg::ACT_REGISTER,   8'h00, 8'h00, 8'h00, 64'd0, 16'h1234);
        add_step(ptst_pkg::ACT_REGISTER,   8'h80, 8'h00, 8'h00, 64'd0, 16'h8001);
        add_step(ptst_pkg::ACT_REGISTER,   8'hFF, 8'h00, 8'h00, 64'd0, 16'h0001);
        add_step(ptst_pkg::ACT_REGISTER,   8'h01, 8'h00, 8'h00, 64'd0, 16'h0000);
        add_step(ptst_pkg::ACT_REGISTER,   8'h7F, 8'h00, 8'h00, 64'd0, 16'hFFFE);
        add_step(ptst_pkg::ACT_REGISTER,   8'h00, 8'h00, 8'h00, 64'd0, 16'h00FF);
        add_step(ptst_pkg::ACT_REGISTER,   8'h10, 8'h00, 8'h00, 64'd0, 16'h0042, 1'b1,
                 RES_FAIL);
        add_step(ptst_pkg::ACT_UNREGISTER, 8'h00, 8'h01, 8'h00, 64'd0, 16'h0000);
        add_step(ptst_pkg::ACT_UNREGISTER, 8'h00, 8'h01, 8'h00, 64'd0, 16'h0000, 1'b1,
                 RES_FAIL);

        foreach (directed_steps[i])
            issue_cmd(directed_steps[i].c, directed_steps[i].typed, directed_steps[i].r, 21);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 21 : (phase == 1) ? 59 : 0;
            repeat (ITEMS_PER_PHASE)
                issue_cmd(make_random_cmd(), 1'b0, RES_FAIL, idle_pct);
            wait_drained();
        end

        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("priority_timer_slot_table_top regression: pass");
        else
            $display("priority_timer_slot_table_top regression: fail");
        $finish;
    end

endmodule
